// ===== src/pumrd_pkg.sv =====
// ----------------------------------------------------------------------------
// pumrd_pkg
// Shared types and constants of the per-user mutation rate deviation scorer.
// ----------------------------------------------------------------------------
package pumrd_pkg;

    localparam int USER_SLOTS = 64;
    localparam int HIST_DEPTH = 1024;

    localparam int USER_W   = 6;
    localparam int HEAD_W   = 10;
    localparam int FILL_W   = 11;
    localparam int CNT_W    = 32;
    localparam int TS_W     = 64;
    localparam int TADDR_W  = USER_W + HEAD_W;
    localparam int WIN_W    = 32;
    localparam int MINEV_W  = 16;
    localparam int WGT_W    = 16;
    localparam int SCORE_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Quotient widths: rates are below 2^53 in Q.16
    localparam int RATE_W  = 53;
    localparam int DVD_W   = 80;
    localparam int DSR_W   = 64;
    localparam int DCNT_W  = 7;

    localparam logic [25:0] US_PER_MINUTE = 26'd60000000;
    localparam logic [RATE_W-1:0] ONE_Q16 = RATE_W'(65536);

    localparam logic [WIN_W-1:0]   WINDOW_RST = 32'd60000000;
    localparam logic [MINEV_W-1:0] MINEV_RST  = 16'd20;
    localparam logic [WGT_W-1:0]   WGT_RST    = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW = 2'd0,
        CFG_MINEV  = 2'd1,
        CFG_WEIGHT = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_OLD,
        S_OLDW,
        S_WALK,
        S_SPAN,
        S_DIVA,
        S_DIVR,
        S_MUL0,
        S_MUL1,
        S_DIVS,
        S_DIVSW,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  events;
        logic [FILL_W-1:0] fill;
        logic [HEAD_W-1:0] head;
    } meta_t;

    localparam int META_W = $bits(meta_t);

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/pumrd_if.sv =====
// ----------------------------------------------------------------------------
// pumrd interfaces
// Event, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pumrd_evt_if;
    logic                          valid;
    logic                          ready;
    logic [pumrd_pkg::USER_W-1:0]  user_index;
    logic                          is_mutation;
    logic [pumrd_pkg::TS_W-1:0]    event_time;

    modport source (output valid, user_index, is_mutation, event_time, input ready);
    modport sink   (input valid, user_index, is_mutation, event_time, output ready);
endinterface

interface pumrd_res_if;
    logic                          valid;
    logic                          ready;
    logic [pumrd_pkg::SCORE_W-1:0] deviation_score;
    logic                          baseline_ready;
    logic [pumrd_pkg::CNT_W-1:0]   event_total;

    modport source (output valid, deviation_score, baseline_ready, event_total, input ready);
    modport sink   (input valid, deviation_score, baseline_ready, event_total, output ready);
endinterface

interface pumrd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pumrd_pkg::CFG_IDX_W-1:0] index;
    logic [pumrd_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/per_user_mutation_rate_deviation.sv =====
// ----------------------------------------------------------------------------
// per_user_mutation_rate_deviation
// Per-user mutation rate deviation scorer over a timestamp ring in RAM.
// ----------------------------------------------------------------------------
// Accept to result word: below the baseline the event passes S_UPD and S_OUT; with a
// baseline it reads the oldest stored time, walks the stored times backward (at most
// 1024 reads) and runs up to three divisions before S_OUT (one when the average is zero).
// Throughput: one event in flight; the walk (one RAM read a cycle) and the divider set it.
// Reset: configuration returns to its defaults and all user slots read as empty;
// the timestamp RAM is not cleared, so the block takes events right after reset.
module per_user_mutation_rate_deviation (
    input  logic           clk,
    input  logic           rst_n,
    pumrd_evt_if.sink      evt,
    pumrd_res_if.source    res,
    pumrd_cfg_if.sink      cfg
);

    // configuration registers
    logic [pumrd_pkg::WIN_W-1:0]   window_reg;
    logic [pumrd_pkg::MINEV_W-1:0] minev_reg;
    logic [pumrd_pkg::WGT_W-1:0]   weight_reg;

    // sequencer
    pumrd_pkg::state_t state_reg, state_next;

    // per-slot metadata valid bits: an empty slot reads as zero
    logic [pumrd_pkg::USER_SLOTS-1:0] valid_reg, valid_next;

    // event context
    logic [pumrd_pkg::USER_W-1:0] user_reg, user_next;
    logic                         mut_reg, mut_next;
    logic [pumrd_pkg::TS_W-1:0]   now_reg, now_next;
    logic [pumrd_pkg::TS_W-1:0]   thr_reg, thr_next;
    pumrd_pkg::meta_t             meta_reg, meta_next;
    logic                         base_reg, base_next;

    // walk and arithmetic
    logic [pumrd_pkg::FILL_W-1:0] k_reg, k_next;
    logic                         pend_reg, pend_next;
    logic                         first_reg, first_next;
    logic [pumrd_pkg::FILL_W-1:0] recent_reg, recent_next;
    logic [pumrd_pkg::TS_W-1:0]   newest_reg, newest_next;
    logic [pumrd_pkg::TS_W-1:0]   oldest_reg, oldest_next;
    logic [pumrd_pkg::RATE_W-1:0] avg_reg, avg_next;
    logic [pumrd_pkg::RATE_W-1:0] diff_reg, diff_next;
    logic [42:0]                  plo_reg, plo_next;
    logic [41:0]                  phi_reg, phi_next;
    logic [pumrd_pkg::SCORE_W-1:0] score_reg, score_next;

    // output word
    logic                          out_valid_reg, out_valid_next;
    logic [pumrd_pkg::SCORE_W-1:0] out_score_reg, out_score_next;
    logic                          out_base_reg, out_base_next;
    logic [pumrd_pkg::CNT_W-1:0]   out_total_reg, out_total_next;

    // memories
    logic                          meta_we;
    logic [pumrd_pkg::META_W-1:0]  meta_rdata;
    pumrd_pkg::meta_t              meta_cur;
    logic                          time_we;
    logic [pumrd_pkg::TADDR_W-1:0] time_waddr, time_raddr;
    logic [pumrd_pkg::TS_W-1:0]    time_rdata;

    pumrd_pkg::div_req_t div_req;
    pumrd_pkg::div_rsp_t div_rsp;

    // combinational helpers
    pumrd_pkg::meta_t              upd;
    logic [pumrd_pkg::WIN_W-1:0]   win;
    logic [pumrd_pkg::HEAD_W-1:0]  oldest_idx, walk_idx;
    logic                          rd_hit, stop, issue;
    logic [pumrd_pkg::TS_W-1:0]    span;
    logic [36:0]                   avg_num, rate_num;
    logic [pumrd_pkg::RATE_W-1:0]  rate_q;
    logic [76:0]                   prod;
    logic [pumrd_pkg::RATE_W-1:0]  denom;

    pumrd_ram #(
        .WIDTH (pumrd_pkg::META_W),
        .DEPTH (pumrd_pkg::USER_SLOTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (user_reg),
        .wdata (upd),
        .raddr (evt.user_index),
        .rdata (meta_rdata)
    );

    pumrd_ram #(
        .WIDTH (pumrd_pkg::TS_W),
        .DEPTH (pumrd_pkg::USER_SLOTS * pumrd_pkg::HIST_DEPTH)
    ) u_time_ram (
        .clk   (clk),
        .we    (time_we),
        .waddr (time_waddr),
        .wdata (now_reg),
        .raddr (time_raddr),
        .rdata (time_rdata)
    );

    pumrd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // configuration writes are always taken; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= pumrd_pkg::WINDOW_RST;
            minev_reg  <= pumrd_pkg::MINEV_RST;
            weight_reg <= pumrd_pkg::WGT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pumrd_pkg::CFG_WINDOW: window_reg <= cfg.data;
                pumrd_pkg::CFG_MINEV:  minev_reg  <= cfg.data[pumrd_pkg::MINEV_W-1:0];
                pumrd_pkg::CFG_WEIGHT: weight_reg <= cfg.data[pumrd_pkg::WGT_W-1:0];
                default: ;
            endcase
        end
    end

    assign evt.ready           = (state_reg == pumrd_pkg::S_IDLE);
    assign res.valid           = out_valid_reg;
    assign res.deviation_score = out_score_reg;
    assign res.baseline_ready  = out_base_reg;
    assign res.event_total     = out_total_reg;

    always_comb
    begin
        // a zero window counts as one microsecond
        win = (window_reg == '0) ? pumrd_pkg::WIN_W'(1) : window_reg;

        // slot state as read, zero until the slot is first written
        meta_cur = valid_reg[user_reg] ? pumrd_pkg::meta_t'(meta_rdata) : '0;

        // record the event: saturating count, ring advance on a mutation
        upd.events = (meta_cur.events == '1) ? meta_cur.events : meta_cur.events + 1'b1;
        upd.head   = mut_reg ? meta_cur.head + 1'b1 : meta_cur.head;
        upd.fill   = (mut_reg && meta_cur.fill < pumrd_pkg::FILL_W'(pumrd_pkg::HIST_DEPTH))
                     ? meta_cur.fill + 1'b1 : meta_cur.fill;

        oldest_idx = meta_reg.head - meta_reg.fill[pumrd_pkg::HEAD_W-1:0];
        walk_idx   = meta_reg.head - 1'b1 - k_reg[pumrd_pkg::HEAD_W-1:0];

        rd_hit = (time_rdata >= thr_reg);
        stop   = pend_reg && !rd_hit;
        issue  = (k_reg < meta_reg.fill) && !stop;

        span     = newest_reg - oldest_reg;
        avg_num  = 37'(meta_reg.fill) * 37'(pumrd_pkg::US_PER_MINUTE);
        rate_num = 37'(recent_reg) * 37'(pumrd_pkg::US_PER_MINUTE);
        rate_q   = div_rsp.quotient[pumrd_pkg::RATE_W-1:0];
        prod     = 77'({(77'(phi_reg) << 27) + 77'(plo_reg), 8'b0});
        denom    = (avg_reg > pumrd_pkg::ONE_Q16) ? avg_reg : pumrd_pkg::ONE_Q16;

        state_next     = state_reg;
        valid_next     = valid_reg;
        user_next      = user_reg;
        mut_next       = mut_reg;
        now_next       = now_reg;
        thr_next       = thr_reg;
        meta_next      = meta_reg;
        base_next      = base_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        first_next     = first_reg;
        recent_next    = recent_reg;
        newest_next    = newest_reg;
        oldest_next    = oldest_reg;
        avg_next       = avg_reg;
        diff_next      = diff_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        score_next     = score_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_score_next = out_score_reg;
        out_base_next  = out_base_reg;
        out_total_next = out_total_reg;

        meta_we    = 1'b0;
        time_we    = 1'b0;
        time_waddr = {user_reg, meta_cur.head};
        time_raddr = {user_reg, walk_idx};
        div_req    = '0;

        case (state_reg)
            pumrd_pkg::S_IDLE:
            begin
                // slot metadata read is issued on the event address
                if (evt.valid)
                begin
                    user_next  = evt.user_index;
                    mut_next   = evt.is_mutation;
                    now_next   = evt.event_time;
                    state_next = pumrd_pkg::S_UPD;
                end
            end
            pumrd_pkg::S_UPD:
            begin
                meta_we              = 1'b1;
                time_we              = mut_reg;
                valid_next[user_reg] = 1'b1;
                meta_next            = upd;
                thr_next             = now_reg - pumrd_pkg::TS_W'(win);
                base_next            = (upd.events >= pumrd_pkg::CNT_W'(minev_reg));
                score_next           = '0;
                state_next           = base_next ? pumrd_pkg::S_OLD : pumrd_pkg::S_OUT;
            end
            pumrd_pkg::S_OLD:
            begin
                time_raddr = {user_reg, oldest_idx};
                state_next = pumrd_pkg::S_OLDW;
            end
            pumrd_pkg::S_OLDW:
            begin
                oldest_next = time_rdata;
                k_next      = '0;
                pend_next   = 1'b0;
                first_next  = 1'b1;
                recent_next = '0;
                state_next  = pumrd_pkg::S_WALK;
            end
            pumrd_pkg::S_WALK:
            begin
                // one read issued, one compared per cycle; stop at the first old entry
                if (pend_reg && first_reg)
                begin
                    newest_next = time_rdata;
                    first_next  = 1'b0;
                end
                if (pend_reg && rd_hit)
                begin
                    recent_next = recent_reg + 1'b1;
                end
                k_next    = k_reg + pumrd_pkg::FILL_W'(issue);
                pend_next = issue;
                if (stop || (!issue && !pend_reg))
                begin
                    state_next = pumrd_pkg::S_SPAN;
                end
            end
            pumrd_pkg::S_SPAN:
            begin
                if (meta_reg.fill == '0 || span == '0)
                begin
                    state_next = pumrd_pkg::S_OUT;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = pumrd_pkg::DVD_W'({avg_num, 16'b0});
                    div_req.divisor  = span;
                    state_next       = pumrd_pkg::S_DIVA;
                end
            end
            pumrd_pkg::S_DIVA:
            begin
                if (div_rsp.done)
                begin
                    avg_next = rate_q;
                    if (div_rsp.quotient == '0)
                    begin
                        state_next = pumrd_pkg::S_OUT;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = pumrd_pkg::DVD_W'({rate_num, 16'b0});
                        div_req.divisor  = pumrd_pkg::DSR_W'(win);
                        state_next       = pumrd_pkg::S_DIVR;
                    end
                end
            end
            pumrd_pkg::S_DIVR:
            begin
                if (div_rsp.done)
                begin
                    diff_next  = (rate_q > avg_reg) ? rate_q - avg_reg : avg_reg - rate_q;
                    state_next = pumrd_pkg::S_MUL0;
                end
            end
            pumrd_pkg::S_MUL0:
            begin
                plo_next   = 43'(diff_reg[26:0]) * 43'(weight_reg);
                state_next = pumrd_pkg::S_MUL1;
            end
            pumrd_pkg::S_MUL1:
            begin
                phi_next   = 42'(diff_reg[pumrd_pkg::RATE_W-1:27]) * 42'(weight_reg);
                state_next = pumrd_pkg::S_DIVS;
            end
            pumrd_pkg::S_DIVS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = pumrd_pkg::DVD_W'(prod);
                div_req.divisor  = pumrd_pkg::DSR_W'(denom);
                state_next       = pumrd_pkg::S_DIVSW;
            end
            pumrd_pkg::S_DIVSW:
            begin
                if (div_rsp.done)
                begin
                    // saturate to the Q16.16 range
                    score_next = (div_rsp.quotient[pumrd_pkg::DVD_W-1:pumrd_pkg::SCORE_W] != '0)
                                 ? '1 : div_rsp.quotient[pumrd_pkg::SCORE_W-1:0];
                    state_next = pumrd_pkg::S_OUT;
                end
            end
            pumrd_pkg::S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_score_next = score_reg;
                    out_base_next  = base_reg;
                    out_total_next = meta_reg.events;
                    state_next     = pumrd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pumrd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pumrd_pkg::S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        user_reg      <= user_next;
        mut_reg       <= mut_next;
        now_reg       <= now_next;
        thr_reg       <= thr_next;
        meta_reg      <= meta_next;
        base_reg      <= base_next;
        k_reg         <= k_next;
        recent_reg    <= recent_next;
        newest_reg    <= newest_next;
        oldest_reg    <= oldest_next;
        avg_reg       <= avg_next;
        diff_reg      <= diff_next;
        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        score_reg     <= score_next;
        out_score_reg <= out_score_next;
        out_base_reg  <= out_base_next;
        out_total_reg <= out_total_next;
    end

endmodule

// ===== src/pumrd_ram.sv =====
// ----------------------------------------------------------------------------
// pumrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pumrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/pumrd_div.sv =====
// ----------------------------------------------------------------------------
// pumrd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pumrd_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pumrd_pkg::div_req_t req,
    output pumrd_pkg::div_rsp_t rsp
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [pumrd_pkg::DCNT_W-1:0]    cnt_reg, cnt_next;
    logic [pumrd_pkg::DSR_W-1:0]     rem_reg, rem_next;
    logic [pumrd_pkg::DVD_W-1:0]     dvd_reg, dvd_next;
    logic [pumrd_pkg::DSR_W-1:0]     dsr_reg, dsr_next;
    logic [pumrd_pkg::DSR_W:0]       rem_sh;
    logic                            qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_sh    = {rem_reg, dvd_reg[pumrd_pkg::DVD_W-1]};
        qbit      = (rem_sh >= {1'b0, dsr_reg});
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = pumrd_pkg::DCNT_W'(pumrd_pkg::DVD_W);
            rem_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract where it fits
            rem_next = qbit ? pumrd_pkg::DSR_W'(rem_sh - {1'b0, dsr_reg})
                            : rem_sh[pumrd_pkg::DSR_W-1:0];
            dvd_next = {dvd_reg[pumrd_pkg::DVD_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == pumrd_pkg::DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

// ===== src/pumrd_checker.sv =====
// ----------------------------------------------------------------------------
// pumrd_checker
// Port-level checks of the deviation scorer, bound to the top level.
// ----------------------------------------------------------------------------
module pumrd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          evt_valid,
    input logic                          evt_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [pumrd_pkg::SCORE_W-1:0] res_score,
    input logic                          res_base,
    input logic [pumrd_pkg::CNT_W-1:0]   res_total
);

    // a stalled result word stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    // one event at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !evt_ready)
        else $error("event accepted while previous one in flight");

    // below the baseline the score is zero
    a_no_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_base |-> res_score == '0)
        else $error("score given below baseline");

    // every result counts at least its own event
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_total != '0)
        else $error("result with zero event total");

endmodule

bind per_user_mutation_rate_deviation pumrd_checker u_pumrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_score (res.deviation_score),
    .res_base  (res.baseline_ready),
    .res_total (res.event_total)
);
